[rtl/tdes_pkg.sv]
// ----------------------------------------------------------------------------
// Triple DES package
// DES permutation tables, S-boxes and round helpers shared by the cipher.
// ----------------------------------------------------------------------------
package tdes_pkg;

  localparam int unsigned BlockW = 64;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_ONE   = 3'd0,
    REG_KEY_TWO   = 3'd1,
    REG_KEY_THREE = 3'd2,
    REG_INIT_VEC  = 3'd3,
    REG_DECRYPT   = 3'd4
  } cfg_reg_e;

  typedef logic [7:0] tab64_t [64];
  typedef logic [7:0] tab56_t [56];
  typedef logic [7:0] tab48_t [48];
  typedef logic [7:0] tab32_t [32];
  typedef logic [3:0] sbox_t  [8][64];

  localparam tab64_t TabIp = '{
    58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,62,54,46,38,30,22,14,6,
    64,56,48,40,32,24,16,8,57,49,41,33,25,17,9,1,59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};
  localparam tab64_t TabFp = '{
    40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,38,6,46,14,54,22,62,30,
    37,5,45,13,53,21,61,29,36,4,44,12,52,20,60,28,35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};
  localparam tab48_t TabE = '{
    32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
    16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};
  localparam tab32_t TabP = '{
    16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,2,8,24,14,32,27,3,9,
    19,13,30,6,22,11,4,25};
  localparam tab56_t TabPc1 = '{
    57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,
    60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,61,53,45,37,
    29,21,13,5,28,20,12,4};
  localparam tab48_t TabPc2 = '{
    14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
    41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};
  localparam logic [15:0] ShiftTwo = 16'b0111_1110_1111_1100; // bit r: round r shifts 2

  localparam sbox_t TabS = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  function automatic logic [63:0] perm_ip(logic [63:0] x);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = x[64-int'(TabIp[i])];
    return r;
  endfunction

  function automatic logic [63:0] perm_fp(logic [63:0] x);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = x[64-int'(TabFp[i])];
    return r;
  endfunction

  function automatic logic [55:0] perm_pc1(logic [63:0] x);
    logic [55:0] r;
    for (int i = 0; i < 56; i++) r[55-i] = x[64-int'(TabPc1[i])];
    return r;
  endfunction

  function automatic logic [47:0] perm_pc2(logic [55:0] x);
    logic [47:0] r;
    for (int i = 0; i < 48; i++) r[47-i] = x[56-int'(TabPc2[i])];
    return r;
  endfunction

  function automatic logic [31:0] round_f(logic [31:0] half, logic [47:0] rk);
    logic [47:0] e;
    logic [31:0] acc;
    logic [31:0] p;
    logic [5:0]  six;
    for (int i = 0; i < 48; i++) e[47-i] = half[32-int'(TabE[i])];
    e = e ^ rk;
    for (int i = 0; i < 8; i++) begin
      six = e[42-6*i +: 6];
      acc[28-4*i +: 4] = TabS[i][{six[5], six[0], six[4:1]}];
    end
    for (int i = 0; i < 32; i++) p[31-i] = acc[32-int'(TabP[i])];
    return p;
  endfunction

  function automatic logic odd_parity_ok(logic [63:0] k);
    logic ok;
    ok = 1'b1;
    for (int b = 0; b < 8; b++) ok = ok & (^k[8*b +: 8]);
    return ok;
  endfunction

endpackage

[rtl/tdes_round.sv]
// ----------------------------------------------------------------------------
// DES round unit
// One Feistel round plus key-register rotation, forward or backward.
// ----------------------------------------------------------------------------
module tdes_round (
  input  logic        backward_i,
  input  logic        shift_two_i,
  input  logic [63:0] lr_i,
  input  logic [55:0] cd_i,
  output logic [63:0] lr_o,
  output logic [55:0] cd_o
);
  import tdes_pkg::*;

  logic [27:0] c, d, cn, dn;
  logic [55:0] cd_use;

  assign c = cd_i[55:28];
  assign d = cd_i[27:0];

  always_comb begin
    if (!backward_i) begin
      // rotate left before the round key is taken
      cn = shift_two_i ? {c[25:0], c[27:26]} : {c[26:0], c[27]};
      dn = shift_two_i ? {d[25:0], d[27:26]} : {d[26:0], d[27]};
      cd_use = {cn, dn};
    end else begin
      // key taken from the current value, then rotate right
      cn = shift_two_i ? {c[1:0], c[27:2]} : {c[0], c[27:1]};
      dn = shift_two_i ? {d[1:0], d[27:2]} : {d[0], d[27:1]};
      cd_use = cd_i;
    end
  end

  assign cd_o = {cn, dn};
  assign lr_o = {lr_i[31:0], lr_i[63:32] ^ round_f(lr_i[31:0], perm_pc2(cd_use))};

endmodule

[rtl/triple_des_cbc_cipher_top.sv]
// ----------------------------------------------------------------------------
// Triple DES EDE3 CBC cipher
// Block cipher with CBC chaining, keys and IV held in a register memory.
// ----------------------------------------------------------------------------
// A block goes from accept to result in order: read the IV or chain value
// from memory, load the first pass, run three DES passes of sixteen rounds at
// one round per cycle through a single shared round unit, and finish and
// register the result. Only one block is in flight; the next is accepted once
// the result beat has left. A decrypt with a key of bad odd parity returns
// zero with the error flag set. Keys, IV and the chain value sit in a 6-entry
// register file, the mode in a flop of its own; the link value is read
// through a registered port.
module triple_des_cbc_cipher_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [63:0] data_in
  input  logic        s_axis_tuser,   // [0] first_block
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] data_out
  output logic        m_axis_tuser,   // [0] parity_error
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import tdes_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_READ  = 5'b00010,
    ST_LOAD  = 5'b00100,
    ST_ROUND = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  localparam logic [2:0] ChainAddr = 3'd5;

  // register file: keys, IV, chain value. All entries reset to zero.
  logic [63:0] mem_q [6];
  logic        mode_q;
  logic [63:0] link_q;

  state_e      state_q, state_d;
  logic [63:0] blk_q, lr_q, res_q;
  logic [55:0] cd_q;
  logic [3:0]  rnd_q;
  logic [1:0]  pass_q;
  logic        first_q, err_q, out_valid_q;
  logic        par_ok;

  logic        backward;
  logic [2:0]  key_sel;
  logic [63:0] lr_n;
  logic [55:0] cd_n;
  logic        in_beat, out_beat;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE) && !out_valid_q;
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign out_beat      = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_q;
  assign m_axis_tuser  = err_q;

  assign par_ok = odd_parity_ok(mem_q[REG_KEY_ONE]) && odd_parity_ok(mem_q[REG_KEY_TWO])
                  && odd_parity_ok(mem_q[REG_KEY_THREE]);

  // pass order: encrypt K1 fwd, K2 back, K3 fwd; decrypt K3 back, K2 fwd, K1 back
  always_comb begin
    unique case (pass_q)
      2'd0:    key_sel = mode_q ? REG_KEY_THREE : REG_KEY_ONE;
      2'd1:    key_sel = REG_KEY_TWO;
      default: key_sel = mode_q ? REG_KEY_ONE : REG_KEY_THREE;
    endcase
    backward = mode_q ^ pass_q[0];
  end

  tdes_round u_round (
    .backward_i  (backward),
    .shift_two_i (ShiftTwo[backward ? 4'd15 - rnd_q : rnd_q]),
    .lr_i        (lr_q),
    .cd_i        (cd_q),
    .lr_o        (lr_n),
    .cd_o        (cd_n)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) mem_q[i] <= '0;
      mode_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_DECRYPT) mode_q <= cfg_data_i[0];
        else if (cfg_index_i < REG_DECRYPT) mem_q[cfg_index_i] <= cfg_data_i;
      end
      // write back the chain value at the end of a block
      if (state_q == ST_DONE) mem_q[ChainAddr] <= mode_q ? blk_q : perm_fp(lr_q);
    end
  end

  // registered read of the link value
  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) link_q <= first_q ? mem_q[REG_INIT_VEC] : mem_q[ChainAddr];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_beat) state_d = ST_READ;
      ST_READ:  state_d = ST_LOAD;
      ST_LOAD:  state_d = ST_ROUND;
      ST_ROUND: if (rnd_q == 4'd15 && pass_q == 2'd2) state_d = ST_DONE;
      ST_DONE:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      rnd_q       <= '0;
      pass_q      <= '0;
    end else begin
      state_q <= state_d;
      if (out_beat) out_valid_q <= 1'b0;
      if (state_q == ST_DONE) out_valid_q <= 1'b1;
      // clear the counters before the load cycle picks the first key
      if (state_q == ST_READ) begin
        rnd_q  <= '0;
        pass_q <= '0;
      end else if (state_q == ST_ROUND) begin
        rnd_q <= rnd_q + 4'd1;
        if (rnd_q == 4'd15) pass_q <= pass_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      blk_q   <= s_axis_tdata;
      first_q <= s_axis_tuser;
    end
    unique case (state_q)
      ST_LOAD: begin
        lr_q <= perm_ip(mode_q ? blk_q : blk_q ^ link_q);
        cd_q <= perm_pc1(mem_q[key_sel]);
      end
      ST_ROUND: begin
        if (rnd_q == 4'd15) begin
          // swap halves, final permute, start next pass
          lr_q <= perm_ip(perm_fp({lr_n[31:0], lr_n[63:32]}));
          cd_q <= perm_pc1(mem_q[mode_q ? (pass_q == 2'd0 ? REG_KEY_TWO : REG_KEY_ONE)
                                         : (pass_q == 2'd0 ? REG_KEY_TWO : REG_KEY_THREE)]);
        end else begin
          lr_q <= lr_n;
          cd_q <= cd_n;
        end
      end
      ST_DONE: begin
        if (mode_q && !par_ok) begin
          res_q <= '0;
          err_q <= 1'b1;
        end else begin
          res_q <= perm_fp(lr_q) ^ (mode_q ? link_q : 64'd0);
          err_q <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> state_q == ST_READ) else $error("accept did not start a block");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE |=> out_valid_q) else $error("result not presented");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !s_axis_tready) else $error("accept while result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ROUND |-> pass_q != 2'd3) else $error("pass counter overrun");

endmodule

[verif/tb_triple_des_cbc_cipher_top.sv]
// ----------------------------------------------------------------------------
// Triple DES EDE3 CBC cipher testbench
// Drives a directed table and then random CBC messages under several key, IV
// and mode settings. A local DES/CBC predictor queues the expected blocks and
// every output beat is checked against the oldest one. Both stream sides idle
// and stall at random.
// ----------------------------------------------------------------------------
module tb_triple_des_cbc_cipher_top;
  import tdes_pkg::*;

  localparam logic [2:0] RegUnusedLo = 3'd5;
  localparam logic [2:0] RegUnusedHi = 3'd7;
  localparam int unsigned SettleCycles = 60;
  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned RandomItems = 1850;
  localparam int unsigned KeyShift [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

  typedef enum logic { ROW_CFG, ROW_BLOCK } row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [2:0]  idx;       // register index for ROW_CFG
    logic        first;     // first_block for ROW_BLOCK
    logic [63:0] value;     // register data or input block
    logic        typed;     // expected result given in the row
    logic [63:0] want_data;
    logic        want_err;
  } dir_row_t;

  typedef struct {
    logic [63:0] data;
    logic        err;
  } cipher_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // [63:0] data_in
  logic        s_axis_tuser = 1'b0; // [0] first_block
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // [63:0] data_out
  logic        m_axis_tuser;        // [0] parity_error
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  triple_des_cbc_cipher_top dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor state
  logic [63:0] mdl_key [3];
  logic [63:0] mdl_iv;
  logic        mdl_decrypt;
  logic [63:0] mdl_chain;

  cipher_out_t pending_blocks [$];
  int unsigned mismatch_cnt = 0;
  int unsigned idle_cycles = 0;
  bit          hold_sink = 1'b0;
  bit          free_sink = 1'b0;

  function automatic logic [47:0] subkey(logic [63:0] key, int unsigned rnd);
    logic [55:0] cd;
    logic [27:0] c;
    logic [27:0] d;
    logic [47:0] sk;
    for (int i = 0; i < 56; i++) cd[55-i] = key[64-int'(TabPc1[i])];
    c = cd[55:28];
    d = cd[27:0];
    for (int r = 0; r <= rnd; r++) begin
      c = (c << KeyShift[r]) | (c >> (28 - KeyShift[r]));
      d = (d << KeyShift[r]) | (d >> (28 - KeyShift[r]));
    end
    cd = {c, d};
    for (int i = 0; i < 48; i++) sk[47-i] = cd[56-int'(TabPc2[i])];
    return sk;
  endfunction

  function automatic logic [31:0] feistel(logic [31:0] half, logic [47:0] rk);
    logic [47:0] e;
    logic [31:0] sb;
    logic [31:0] p;
    logic [5:0]  six;
    for (int i = 0; i < 48; i++) e[47-i] = half[32-int'(TabE[i])];
    e ^= rk;
    for (int i = 0; i < 8; i++) begin
      six = e[42-6*i +: 6];
      sb[28-4*i +: 4] = TabS[i][{six[5], six[0], six[4:1]}];
    end
    for (int i = 0; i < 32; i++) p[31-i] = sb[32-int'(TabP[i])];
    return p;
  endfunction

  function automatic logic [63:0] des_pass(logic [63:0] blk, logic [63:0] key, bit inverse);
    logic [63:0] x;
    logic [63:0] y;
    logic [31:0] l;
    logic [31:0] r;
    logic [31:0] t;
    for (int i = 0; i < 64; i++) x[63-i] = blk[64-int'(TabIp[i])];
    l = x[63:32];
    r = x[31:0];
    for (int i = 0; i < 16; i++) begin
      t = r;
      r = l ^ feistel(r, subkey(key, inverse ? 15 - i : i));
      l = t;
    end
    x = {r, l};
    for (int i = 0; i < 64; i++) y[63-i] = x[64-int'(TabFp[i])];
    return y;
  endfunction

  function automatic bit key_parity_ok(logic [63:0] k);
    for (int b = 0; b < 8; b++) if (!(^k[8*b +: 8])) return 1'b0;
    return 1'b1;
  endfunction

  function automatic cipher_out_t cbc_step(logic [63:0] blk, logic first);
    cipher_out_t o;
    logic [63:0] link;
    link = first ? mdl_iv : mdl_chain;
    o.err = 1'b0;
    if (!mdl_decrypt) begin
      o.data = des_pass(blk ^ link, mdl_key[0], 1'b0);
      o.data = des_pass(o.data, mdl_key[1], 1'b1);
      o.data = des_pass(o.data, mdl_key[2], 1'b0);
      mdl_chain = o.data;
    end else begin
      if (key_parity_ok(mdl_key[0]) && key_parity_ok(mdl_key[1]) &&
          key_parity_ok(mdl_key[2])) begin
        o.data = des_pass(blk, mdl_key[2], 1'b1);
        o.data = des_pass(o.data, mdl_key[1], 1'b0);
        o.data = des_pass(o.data, mdl_key[0], 1'b1) ^ link;
      end else begin
        o.data = '0;
        o.err = 1'b1;
      end
      mdl_chain = blk;
    end
    return o;
  endfunction

  // Force odd parity on every key byte
  function automatic logic [63:0] fix_parity(logic [63:0] k);
    for (int b = 0; b < 8; b++) k[8*b] = ~^k[8*b+1 +: 7];
    return k;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic source_gap();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    n = (r < 60) ? 0 : (r < 95) ? $urandom_range(1, 4) : $urandom_range(20, 100);
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_block(logic [63:0] blk, logic first, cipher_out_t typed_out,
                            bit use_typed);
    cipher_out_t o;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= blk;
    s_axis_tuser  <= first;
    do @(posedge clk_i); while (!s_axis_tready);
    o = cbc_step(blk, first);
    pending_blocks.push_back(use_typed ? typed_out : o);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_KEY_ONE:   mdl_key[0] = value;
      REG_KEY_TWO:   mdl_key[1] = value;
      REG_KEY_THREE: mdl_key[2] = value;
      REG_INIT_VEC:  mdl_iv = value;
      REG_DECRYPT:   mdl_decrypt = value[0];
      default: ;
    endcase
    // leave a gap so the next write starts on a fresh edge
    @(posedge clk_i);
  endtask

  dir_row_t dir_rows [] = '{
    '{ROW_BLOCK, '0, 1'b0, 64'h0, 1'b0, '0, 1'b0},
    '{ROW_BLOCK, '0, 1'b1, '1, 1'b0, '0, 1'b0},
    '{ROW_CFG, REG_DECRYPT, 1'b0, 64'h1, 1'b0, '0, 1'b0},
    '{ROW_BLOCK, '0, 1'b1, 64'h0123_4567_89AB_CDEF, 1'b1, '0, 1'b1},
    '{ROW_BLOCK, '0, 1'b0, '1, 1'b1, '0, 1'b1},
    '{ROW_CFG, REG_KEY_ONE, 1'b0, 64'h0101_0101_0101_0101, 1'b0, '0, 1'b0},
    '{ROW_CFG, REG_KEY_TWO, 1'b0, 64'hFEFE_FEFE_FEFE_FEFE, 1'b0, '0, 1'b0},
    '{ROW_CFG, REG_KEY_THREE, 1'b0, 64'h0123_4567_89AB_CDEF, 1'b0, '0, 1'b0},
    '{ROW_BLOCK, '0, 1'b1, 64'h0, 1'b0, '0, 1'b0},
    '{ROW_CFG, REG_INIT_VEC, 1'b0, '1, 1'b0, '0, 1'b0},
    '{ROW_BLOCK, '0, 1'b1, '1, 1'b0, '0, 1'b0},
    '{ROW_BLOCK, '0, 1'b0, 64'h8000_0000_0000_0001, 1'b0, '0, 1'b0},
    '{ROW_CFG, RegUnusedLo, 1'b0, '1, 1'b0, '0, 1'b0},
    '{ROW_CFG, RegUnusedHi, 1'b0, '1, 1'b0, '0, 1'b0},
    '{ROW_BLOCK, '0, 1'b0, 64'h5555_5555_AAAA_AAAA, 1'b0, '0, 1'b0},
    '{ROW_CFG, REG_KEY_THREE, 1'b0, '1, 1'b0, '0, 1'b0},
    '{ROW_BLOCK, '0, 1'b1, 64'h1, 1'b1, '0, 1'b1},
    '{ROW_CFG, REG_DECRYPT, 1'b0, 64'h0, 1'b0, '0, 1'b0},
    '{ROW_BLOCK, '0, 1'b1, '1, 1'b0, '0, 1'b0},
    '{ROW_BLOCK, '0, 1'b0, 64'h0, 1'b0, '0, 1'b0}
  };

  // Output side: random ready, occasional long hold-off
  initial begin
    int unsigned r;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_sink = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (free_sink) begin
          m_axis_tready <= 1'b1;
        end else if (r < 2) begin
          m_axis_tready <= 1'b0;
          repeat ($urandom_range(20, 120)) @(posedge clk_i);
        end else begin
          m_axis_tready <= (r < 75);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cipher_out_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_blocks.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected output beat: data %h err %b", m_axis_tdata, m_axis_tuser);
      end else begin
        want = pending_blocks.pop_front();
        if (m_axis_tdata !== want.data || m_axis_tuser !== want.err) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: expected data %h err %b, got data %h err %b",
                     want.data, want.err, m_axis_tdata, m_axis_tuser);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    cipher_out_t typed_out;
    int unsigned sent;
    int unsigned msg_len;
    int unsigned msg_cnt;
    int unsigned r;
    logic [63:0] k;
    mdl_key = '{default: '0};
    mdl_iv = '0;
    mdl_decrypt = 1'b0;
    mdl_chain = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain();
        write_reg(dir_rows[i].idx, dir_rows[i].value);
      end else begin
        typed_out.data = dir_rows[i].want_data;
        typed_out.err  = dir_rows[i].want_err;
        source_gap();
        send_block(dir_rows[i].value, dir_rows[i].first, typed_out, dir_rows[i].typed);
      end
    end

    sent = 0;
    for (int phase = 0; sent < RandomItems; phase++) begin
      drain();
      // Mostly good-parity keys so decrypt goes deep; some raw and extreme keys
      for (int j = 0; j < 3; j++) begin
        r = $urandom_range(0, 99);
        k = (r < 5) ? '0 : (r < 10) ? '1 : (r < 80) ? fix_parity(rand64()) : rand64();
        write_reg(cfg_reg_e'(REG_KEY_ONE + j), k);
      end
      r = $urandom_range(0, 99);
      write_reg(REG_INIT_VEC, (r < 5) ? '0 : (r < 10) ? '1 : rand64());
      write_reg(REG_DECRYPT, {63'b0, 1'($urandom_range(0, 1))});
      if ($urandom_range(0, 7) == 0) write_reg(3'($urandom_range(5, 7)), rand64());
      free_sink = (phase % 5 == 2);
      if (phase == 3) hold_sink = 1'b1;
      msg_cnt = $urandom_range(1, 4);
      for (int m = 0; m < msg_cnt && sent < RandomItems; m++) begin
        msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
        for (int b = 0; b < msg_len; b++) begin
          r = $urandom_range(0, 99);
          if (!free_sink) source_gap();
          send_block((r < 3) ? '0 : (r < 6) ? '1 : rand64(),
                     (b == 0) ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 29) == 0),
                     typed_out, 1'b0);
          sent++;
        end
      end
    end

    drain();
    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
